// ===== rtl/core/dams_pkg.sv =====
// Package with the mode, command and register codes of the door alert controller.
package dams_pkg;

    // Width of the configuration registers and of the register index.
    localparam int REG_W       = 20;
    localparam int CFG_INDEX_W = 8;

    // Operating modes as reported in mode_code.
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_ALERT = 2'd1;
    localparam logic [1:0] MODE_MUTED = 2'd2;
    localparam logic [1:0] MODE_SIREN = 2'd3;

    // Commands for the melody player.
    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_STOP = 2'd1;
    localparam logic [1:0] CMD_PLAY = 2'd2;
    localparam logic [1:0] CMD_LOOP = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_PAUSE_TICKS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MUTE_TICKS  = 8'd1;

    // Register values after reset.
    localparam logic [REG_W-1:0] PAUSE_TICKS_RST = 20'd3000;
    localparam logic [REG_W-1:0] MUTE_TICKS_RST  = 20'd300000;

endpackage

// ===== rtl/core/dams_if.sv =====
// Channel interfaces for tick items, result items and configuration writes.

// One millisecond tick with the debounced input levels.
interface dams_tick_if;
    logic valid;
    logic ready;
    logic door_open;
    logic mute_pressed;
    logic siren_pressed;
    logic melody_finished;

    modport source (output valid, output door_open, output mute_pressed,
                    output siren_pressed, output melody_finished, input ready);
    modport sink   (input valid, input door_open, input mute_pressed,
                    input siren_pressed, input melody_finished, output ready);
endinterface

// One result per tick: mode, LED levels and melody control.
interface dams_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode_code;
    logic       led_door_on;
    logic       led_mute_on;
    logic       led_siren_on;
    logic [1:0] melody_command;
    logic       melody_advance;

    modport source (output valid, output mode_code, output led_door_on,
                    output led_mute_on, output led_siren_on, output melody_command,
                    output melody_advance, input ready);
    modport sink   (input valid, input mode_code, input led_door_on,
                    input led_mute_on, input led_siren_on, input melody_command,
                    input melody_advance, output ready);
endinterface

// Register write channel.
interface dams_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dams_pkg::CFG_INDEX_W-1:0] index;
    logic [dams_pkg::REG_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/door_alert_mute_siren_controller_unit.sv =====
// Top level of the door alert, mute and siren controller.
//
//  Channel  Direction  Carries
//  -------  ---------  ----------------------------------------------------
//  tick     in         door_open, mute_pressed, siren_pressed, melody_finished
//  result   out        mode_code, three LED levels, melody_command, melody_advance
//  cfg      in         register index and write data (pause and mute timeout)
//
// Each tick's mode update is computed from the tick payload and the state
// registers, and lands in the result register.
// The result register is the only stage, so a tick is taken every cycle
// while the result is taken or the register is empty; a stalled result
// holds the tick channel. Reset clears the mode, the counters and the LEDs,
// and loads the default timeouts. Configuration writes are always taken.
module door_alert_mute_siren_controller_unit #(
    parameter int TIMER_BITS = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    dams_tick_if.sink            tick,
    dams_result_if.source        result,
    dams_cfg_if.sink             cfg
);
    import dams_pkg::*;

    // Compare width that covers both the counters and the registers.
    localparam int CMP_W = (TIMER_BITS > REG_W) ? TIMER_BITS : REG_W;

    logic [REG_W-1:0]      pause_ticks_reg;
    logic [REG_W-1:0]      mute_ticks_reg;
    logic [1:0]            mode_reg, mode_next;
    logic                  pausing_reg, pausing_next;
    logic [TIMER_BITS-1:0] pause_el_reg, pause_el_next;
    logic [TIMER_BITS-1:0] mute_el_reg, mute_el_next;
    logic                  led_door_reg, led_door_next;
    logic                  led_mute_reg, led_mute_next;
    logic                  led_siren_reg, led_siren_next;
    logic [1:0]            cmd_reg, cmd_next;
    logic                  adv_reg, adv_next;
    logic                  out_valid_reg;
    logic                  tick_xfer;
    logic                  pause_done;
    logic                  mute_done;

    // A tick is taken when the result register is free or being emptied.
    assign tick.ready = !out_valid_reg || result.ready;
    assign tick_xfer  = tick.valid && tick.ready;
    assign cfg.ready  = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pause_ticks_reg <= PAUSE_TICKS_RST;
            mute_ticks_reg  <= MUTE_TICKS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PAUSE_TICKS: pause_ticks_reg <= cfg.data;
                REG_MUTE_TICKS:  mute_ticks_reg  <= cfg.data;
                default:         ;
            endcase
        end
    end

    // Mode update for one tick; later checks override earlier ones.
    always_comb
    begin
        mode_next      = mode_reg;
        pausing_next   = pausing_reg;
        pause_el_next  = pause_el_reg;
        mute_el_next   = mute_el_reg;
        led_door_next  = led_door_reg;
        led_mute_next  = led_mute_reg;
        led_siren_next = led_siren_reg;
        cmd_next       = CMD_NONE;
        adv_next       = 1'b0;

        // The elapsed counters advance at the start of the tick and saturate.
        if (pausing_reg && !(&pause_el_reg))
        begin
            pause_el_next = pause_el_reg + 1'b1;
        end
        if ((mode_reg == MODE_MUTED) && !(&mute_el_reg))
        begin
            mute_el_next = mute_el_reg + 1'b1;
        end

        pause_done = CMP_W'(pause_el_next) >= CMP_W'(pause_ticks_reg);
        mute_done  = CMP_W'(mute_el_next) >= CMP_W'(mute_ticks_reg);

        case (mode_reg)
            MODE_IDLE:
            begin
                if (tick.siren_pressed)
                begin
                    cmd_next       = CMD_LOOP;
                    led_siren_next = 1'b1;
                    mode_next      = MODE_SIREN;
                end
                else if (tick.door_open)
                begin
                    cmd_next      = CMD_PLAY;
                    led_door_next = 1'b1;
                    mode_next     = MODE_ALERT;
                end
            end
            MODE_ALERT:
            begin
                adv_next      = 1'b1;
                led_door_next = tick.door_open;
                // Melody done: start a pause, or play again once it has run out.
                if (tick.melody_finished && tick.door_open)
                begin
                    if (!pausing_reg)
                    begin
                        pausing_next  = 1'b1;
                        pause_el_next = '0;
                        cmd_next      = CMD_STOP;
                    end
                    else if (pause_done)
                    begin
                        pausing_next = 1'b0;
                        cmd_next     = CMD_PLAY;
                    end
                end
                if (!tick.door_open)
                begin
                    cmd_next      = CMD_STOP;
                    led_door_next = 1'b0;
                    pausing_next  = 1'b0;
                    mode_next     = MODE_IDLE;
                end
                if (tick.mute_pressed)
                begin
                    cmd_next      = CMD_STOP;
                    led_mute_next = 1'b1;
                    mute_el_next  = '0;
                    pausing_next  = 1'b0;
                    mode_next     = MODE_MUTED;
                end
                if (tick.siren_pressed)
                begin
                    cmd_next       = CMD_LOOP;
                    led_siren_next = 1'b1;
                    pausing_next   = 1'b0;
                    mode_next      = MODE_SIREN;
                end
            end
            MODE_MUTED:
            begin
                led_door_next = tick.door_open;
                if (!tick.door_open)
                begin
                    led_mute_next = 1'b0;
                    pausing_next  = 1'b0;
                    mode_next     = MODE_IDLE;
                end
                // Mute runs out while the door is still open.
                if (mute_done && tick.door_open)
                begin
                    led_mute_next = 1'b0;
                    cmd_next      = CMD_PLAY;
                    pausing_next  = 1'b0;
                    mode_next     = MODE_ALERT;
                end
                if (tick.siren_pressed)
                begin
                    led_mute_next  = 1'b0;
                    cmd_next       = CMD_LOOP;
                    led_siren_next = 1'b1;
                    pausing_next   = 1'b0;
                    mode_next      = MODE_SIREN;
                end
            end
            default:
            begin
                // Siren is latched until reset.
                adv_next = 1'b1;
            end
        endcase
    end

    // State and result registers update together on each tick transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            pausing_reg   <= 1'b0;
            pause_el_reg  <= '0;
            mute_el_reg   <= '0;
            led_door_reg  <= 1'b0;
            led_mute_reg  <= 1'b0;
            led_siren_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick_xfer)
            begin
                mode_reg      <= mode_next;
                pausing_reg   <= pausing_next;
                pause_el_reg  <= pause_el_next;
                mute_el_reg   <= mute_el_next;
                led_door_reg  <= led_door_next;
                led_mute_reg  <= led_mute_next;
                led_siren_reg <= led_siren_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Per-tick melody outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg <= CMD_NONE;
            adv_reg <= 1'b0;
        end
        else if (tick_xfer)
        begin
            cmd_reg <= cmd_next;
            adv_reg <= adv_next;
        end
    end

    // The state registers hold the mode and LEDs of the pending result.
    assign result.valid          = out_valid_reg;
    assign result.mode_code      = mode_reg;
    assign result.led_door_on    = led_door_reg;
    assign result.led_mute_on    = led_mute_reg;
    assign result.led_siren_on   = led_siren_reg;
    assign result.melody_command = cmd_reg;
    assign result.melody_advance = adv_reg;

endmodule

// ===== rtl/core/dams_checker.sv =====
// Port checker for the door alert controller and its bind statement.
module dams_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] mode_code,
    input logic       led_door_on,
    input logic       led_mute_on,
    input logic       led_siren_on,
    input logic [1:0] melody_command,
    input logic       melody_advance
);
    import dams_pkg::*;

    // A stalled result holds its payload.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(mode_code)
            && $stable(melody_command) && $stable(melody_advance)
            && $stable(led_door_on) && $stable(led_mute_on) && $stable(led_siren_on))
        else $error("result payload changed while stalled");

    // Once siren shows, every later result is siren too.
    a_siren_latch: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (mode_code == MODE_SIREN) |=> !res_valid || (mode_code == MODE_SIREN))
        else $error("siren mode left without reset");

    // The siren LED tracks the siren mode.
    a_siren_led: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (led_siren_on == (mode_code == MODE_SIREN)))
        else $error("siren LED disagrees with mode");

    // A siren loop command only comes with siren mode.
    a_loop_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (melody_command == CMD_LOOP) |-> (mode_code == MODE_SIREN))
        else $error("loop command outside siren mode");

    // The mute LED is dark in idle and door alert.
    a_mute_led: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && ((mode_code == MODE_IDLE) || (mode_code == MODE_ALERT)) |-> !led_mute_on)
        else $error("mute LED on outside mute");

endmodule

bind door_alert_mute_siren_controller_unit dams_checker u_dams_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .mode_code      (result.mode_code),
    .led_door_on    (result.led_door_on),
    .led_mute_on    (result.led_mute_on),
    .led_siren_on   (result.led_siren_on),
    .melody_command (result.melody_command),
    .melody_advance (result.melody_advance)
);

// ===== tb/door_alert_mute_siren_controller_unit_tb.sv =====
// Self-checking testbench for the door alert, mute and siren controller unit.
`timescale 1ns / 1ps

module door_alert_mute_siren_controller_unit_tb;
    import dams_pkg::*;

    localparam int TIMER_BITS  = 20;
    localparam int QUIET_LIMIT = 500;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_NONE = 8'hFF;

    // One tick as queued for the driver, with the idle gap that follows it.
    typedef struct {
        bit          door_open;
        bit          mute_pressed;
        bit          siren_pressed;
        bit          melody_finished;
        int unsigned gap;
    } tick_item_t;

    // Expected content of one result transfer.
    typedef struct packed {
        logic [1:0] mode;
        logic       door_lamp;
        logic       mute_lamp;
        logic       siren_lamp;
        logic [1:0] cmd;
        logic       adv;
    } status_t;

    bit clk;
    bit rst_n;

    dams_tick_if   tick_ch ();
    dams_result_if result_ch ();
    dams_cfg_if    cfg_ch ();

    door_alert_mute_siren_controller_unit #(.TIMER_BITS(TIMER_BITS)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Controller state as the testbench tracks it.
    logic [1:0]            ctl_mode    = MODE_IDLE;
    bit                    ctl_pausing = 1'b0;
    logic [TIMER_BITS-1:0] pause_count = '0;
    logic [TIMER_BITS-1:0] mute_count  = '0;
    bit                    door_lamp   = 1'b0;
    bit                    mute_lamp   = 1'b0;
    bit                    siren_lamp  = 1'b0;
    logic [REG_W-1:0]      pause_limit = PAUSE_TICKS_RST;
    logic [REG_W-1:0]      mute_limit  = MUTE_TICKS_RST;

    tick_item_t  tick_backlog[$];
    status_t     status_due[$];

    bit          tick_taken;
    bit          result_taken;
    int unsigned tick_gap;
    int unsigned rx_hold;
    bit          tick_pace;
    int unsigned stall_cap;

    int unsigned ticks_queued;
    int unsigned results_checked;
    int unsigned cfg_writes;
    int unsigned mismatches;
    int unsigned quiet_cycles;
    int unsigned mode_seen[4];

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advances the tracked state by one tick and returns the status it should report.
    function automatic status_t compute_status(bit door, bit mute, bit siren, bit done);
        status_t    s;
        logic [1:0] start_mode;
        start_mode = ctl_mode;
        s.cmd = CMD_NONE;
        s.adv = (start_mode == MODE_ALERT) || (start_mode == MODE_SIREN);

        // Elapsed counters move first and stick at their top value.
        if (ctl_pausing && pause_count != '1)
            pause_count = pause_count + 1'b1;
        if (start_mode == MODE_MUTED && mute_count != '1)
            mute_count = mute_count + 1'b1;

        // Checks run in order, so a later one overrides the command of an earlier one.
        case (start_mode)
            MODE_IDLE:
            begin
                if (siren)
                begin
                    s.cmd = CMD_LOOP;
                    siren_lamp = 1'b1;
                    ctl_mode = MODE_SIREN;
                end
                else if (door)
                begin
                    s.cmd = CMD_PLAY;
                    door_lamp = 1'b1;
                    ctl_mode = MODE_ALERT;
                end
            end
            MODE_ALERT:
            begin
                door_lamp = door;
                if (done && door)
                begin
                    if (!ctl_pausing)
                    begin
                        ctl_pausing = 1'b1;
                        pause_count = '0;
                        s.cmd = CMD_STOP;
                    end
                    else if (pause_count >= pause_limit)
                    begin
                        ctl_pausing = 1'b0;
                        s.cmd = CMD_PLAY;
                    end
                end
                if (!door)
                begin
                    s.cmd = CMD_STOP;
                    door_lamp = 1'b0;
                    ctl_pausing = 1'b0;
                    ctl_mode = MODE_IDLE;
                end
                if (mute)
                begin
                    s.cmd = CMD_STOP;
                    mute_lamp = 1'b1;
                    mute_count = '0;
                    ctl_pausing = 1'b0;
                    ctl_mode = MODE_MUTED;
                end
                if (siren)
                begin
                    s.cmd = CMD_LOOP;
                    siren_lamp = 1'b1;
                    ctl_pausing = 1'b0;
                    ctl_mode = MODE_SIREN;
                end
            end
            MODE_MUTED:
            begin
                door_lamp = door;
                if (!door)
                begin
                    mute_lamp = 1'b0;
                    ctl_pausing = 1'b0;
                    ctl_mode = MODE_IDLE;
                end
                if (mute_count >= mute_limit && door)
                begin
                    mute_lamp = 1'b0;
                    s.cmd = CMD_PLAY;
                    ctl_pausing = 1'b0;
                    ctl_mode = MODE_ALERT;
                end
                if (siren)
                begin
                    mute_lamp = 1'b0;
                    s.cmd = CMD_LOOP;
                    siren_lamp = 1'b1;
                    ctl_pausing = 1'b0;
                    ctl_mode = MODE_SIREN;
                end
            end
            default:
            begin
                // Siren is latched; every input is ignored.
            end
        endcase

        s.mode = ctl_mode;
        s.door_lamp = door_lamp;
        s.mute_lamp = mute_lamp;
        s.siren_lamp = siren_lamp;
        return s;
    endfunction

    // Reports one field that differs from its expected value.
    task automatic check_field(string name, logic [1:0] want, logic [1:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Tick driver: holds an item until its transfer, then waits out its gap.
    always @(negedge clk)
    begin : tick_driver
        tick_item_t it;
        if (rst_n && (!tick_ch.valid || tick_taken))
        begin
            if (tick_gap != 0)
            begin
                tick_ch.valid <= 1'b0;
                tick_gap <= tick_gap - 1;
            end
            else if (tick_backlog.size() != 0)
            begin
                it = tick_backlog.pop_front();
                tick_ch.valid <= 1'b1;
                tick_ch.door_open <= it.door_open;
                tick_ch.mute_pressed <= it.mute_pressed;
                tick_ch.siren_pressed <= it.siren_pressed;
                tick_ch.melody_finished <= it.melody_finished;
                tick_gap <= it.gap;
            end
            else
            begin
                tick_ch.valid <= 1'b0;
            end
        end
    end

    // Result sink: after each transfer, stalls for a freshly drawn number of cycles.
    always @(negedge clk)
    begin : result_pacer
        int unsigned wait_left;
        if (rst_n)
        begin
            wait_left = result_taken ? $urandom_range(0, stall_cap) : rx_hold;
            if (wait_left == 0)
                result_ch.ready <= 1'b1;
            else
            begin
                result_ch.ready <= 1'b0;
                rx_hold <= wait_left - 1;
            end
        end
    end

    // Monitor: tracks register writes, predicts each tick and checks each result.
    always @(posedge clk)
    begin : monitor
        status_t want;
        if (rst_n)
        begin
            tick_taken <= tick_ch.valid && tick_ch.ready;
            result_taken <= result_ch.valid && result_ch.ready;

            if (cfg_ch.valid && cfg_ch.ready)
            begin
                if (cfg_ch.index == REG_PAUSE_TICKS)
                    pause_limit = cfg_ch.data;
                else if (cfg_ch.index == REG_MUTE_TICKS)
                    mute_limit = cfg_ch.data;
                cfg_writes++;
            end

            if (tick_ch.valid && tick_ch.ready)
                status_due.push_back(compute_status(tick_ch.door_open, tick_ch.mute_pressed,
                                                    tick_ch.siren_pressed,
                                                    tick_ch.melody_finished));

            if (result_ch.valid && result_ch.ready)
            begin
                if (status_due.size() == 0)
                begin
                    $display("%0t ns: result transfer with nothing expected, mode %0d cmd %0d",
                             $time, result_ch.mode_code, result_ch.melody_command);
                    mismatches++;
                end
                else
                begin
                    want = status_due.pop_front();
                    check_field("mode_code", want.mode, result_ch.mode_code);
                    check_field("led_door_on", 2'(want.door_lamp),
                                2'(result_ch.led_door_on));
                    check_field("led_mute_on", 2'(want.mute_lamp),
                                2'(result_ch.led_mute_on));
                    check_field("led_siren_on", 2'(want.siren_lamp),
                                2'(result_ch.led_siren_on));
                    check_field("melody_command", want.cmd, result_ch.melody_command);
                    check_field("melody_advance", 2'(want.adv),
                                2'(result_ch.melody_advance));
                    mode_seen[want.mode]++;
                    results_checked++;
                end
            end

            // Watchdog on cycles without any transfer.
            if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                             $time, QUIET_LIMIT, status_due.size());
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    // Writes one register through the configuration channel.
    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [REG_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Appends one tick to the driver's backlog.
    task automatic queue_tick(bit door, bit mute, bit siren, bit done);
        tick_item_t it;
        it.door_open = door;
        it.mute_pressed = mute;
        it.siren_pressed = siren;
        it.melody_finished = done;
        it.gap = tick_pace ? $urandom_range(0, 4) : 0;
        tick_backlog.push_back(it);
        ticks_queued++;
    endtask

    // Waits until every tick is sent and every result checked, plus a short tail.
    task automatic wait_until_drained();
        do
            @(posedge clk);
        while (tick_backlog.size() != 0 || tick_ch.valid || status_due.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    // Mostly door-open stretches with melody ends and mute presses, some noise between.
    task automatic queue_random_phase(int unsigned count);
        int unsigned start;
        int unsigned span;
        int unsigned k;
        start = ticks_queued;
        while (ticks_queued - start < count)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                span = $urandom_range(3, 40);
                for (k = 0; k < span; k++)
                    queue_tick(1'b1, $urandom_range(0, 29) == 0, 1'b0,
                               $urandom_range(0, 2) == 0);
                queue_tick(1'b0, $urandom_range(0, 7) == 0, 1'b0, 1'($urandom_range(0, 1)));
                span = $urandom_range(0, 3);
                for (k = 0; k < span; k++)
                    queue_tick(1'b0, 1'($urandom_range(0, 1)), 1'b0,
                               1'($urandom_range(0, 1)));
            end
            else
            begin
                span = $urandom_range(1, 8);
                for (k = 0; k < span; k++)
                    queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0,
                               1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Stimulus sequence: directed checks, random phases, then the siren latch.
    initial
    begin : stimulus
        logic [REG_W-1:0] pause_val;
        logic [REG_W-1:0] mute_val;
        logic [1:0]       siren_from;
        int unsigned      p;
        int unsigned      k;

        tick_ch.valid = 1'b0;
        tick_ch.door_open = 1'b0;
        tick_ch.mute_pressed = 1'b0;
        tick_ch.siren_pressed = 1'b0;
        tick_ch.melody_finished = 1'b0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        tick_pace = 1'b1;
        stall_cap = 4;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Short timeouts so the directed part reaches both expiries.
        write_register(REG_PAUSE_TICKS, 20'd2);
        write_register(REG_MUTE_TICKS, 20'd3);
        write_register(REG_NONE, REG_W'($urandom_range(0, 1048575)));

        // Idle ignores mute and melody end; door open starts the alert.
        queue_tick(1'b0, 1'b0, 1'b0, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b0, 1'b1);
        queue_tick(1'b1, 1'b0, 1'b0, 1'b0);
        queue_tick(1'b1, 1'b0, 1'b0, 1'b0);
        // Melody end starts a pause; the next melody plays once it has run out.
        queue_tick(1'b1, 1'b0, 1'b0, 1'b1);
        queue_tick(1'b1, 1'b0, 1'b0, 1'b1);
        queue_tick(1'b1, 1'b0, 1'b0, 1'b1);
        queue_tick(1'b1, 1'b0, 1'b0, 1'b0);
        // Door closing ends the alert.
        queue_tick(1'b0, 1'b0, 1'b0, 1'b0);
        // Mute, held button ignored while muted, then timeout back to alert.
        queue_tick(1'b1, 1'b0, 1'b0, 1'b0);
        queue_tick(1'b1, 1'b1, 1'b0, 1'b0);
        queue_tick(1'b1, 1'b0, 1'b0, 1'b0);
        queue_tick(1'b1, 1'b1, 1'b0, 1'b0);
        queue_tick(1'b1, 1'b0, 1'b0, 1'b0);
        // Door closing and mute in one alert tick: mute wins, then the door clears it.
        queue_tick(1'b0, 1'b1, 1'b0, 1'b0);
        queue_tick(1'b0, 1'b0, 1'b0, 1'b0);
        // Mute during a pause cancels the pause.
        queue_tick(1'b1, 1'b0, 1'b0, 1'b0);
        queue_tick(1'b1, 1'b0, 1'b0, 1'b1);
        queue_tick(1'b1, 1'b1, 1'b0, 1'b1);
        queue_tick(1'b1, 1'b0, 1'b0, 1'b1);
        queue_tick(1'b1, 1'b0, 1'b0, 1'b0);
        queue_tick(1'b1, 1'b0, 1'b0, 1'b0);
        // Timeout reached on the tick the door closes: back to idle, no alert.
        queue_tick(1'b1, 1'b1, 1'b0, 1'b0);
        queue_tick(1'b1, 1'b0, 1'b0, 1'b0);
        queue_tick(1'b1, 1'b0, 1'b0, 1'b0);
        queue_tick(1'b0, 1'b0, 1'b0, 1'b0);
        wait_until_drained();

        // Random phases, each with its own timeouts and pacing.
        for (p = 0; p < 10; p++)
        begin
            case (p)
                0:
                begin
                    pause_val = '0;
                    mute_val = '0;
                end
                1:
                begin
                    pause_val = '1;
                    mute_val = '1;
                end
                default:
                begin
                    pause_val = REG_W'($urandom_range(0, 10));
                    mute_val = REG_W'($urandom_range(0, 25));
                end
            endcase
            write_register(REG_PAUSE_TICKS, pause_val);
            write_register(REG_MUTE_TICKS, mute_val);
            tick_pace = (p % 4) < 2;
            stall_cap = (p % 2 == 0) ? 4 : 0;
            queue_random_phase(200);
            wait_until_drained();
        end

        // Siren latches for the rest of the run, so it comes last.
        tick_pace = 1'b1;
        stall_cap = 4;
        queue_tick(1'b0, 1'b0, 1'b0, 1'b0);
        siren_from = 2'($urandom_range(0, 3));
        case (siren_from)
            MODE_IDLE:
            begin
                queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1,
                           1'($urandom_range(0, 1)));
            end
            MODE_MUTED:
            begin
                queue_tick(1'b1, 1'b0, 1'b0, 1'b0);
                queue_tick(1'b1, 1'b1, 1'b0, 1'b0);
                queue_tick(1'($urandom_range(0, 1)), 1'b0, 1'b1, 1'b0);
            end
            default:
            begin
                // Mute and siren in the same alert tick leave the mute LED on.
                queue_tick(1'b1, 1'b0, 1'b0, 1'b0);
                queue_tick(1'b1, 1'b1, 1'b1, 1'($urandom_range(0, 1)));
            end
        endcase
        for (k = 0; k < 40; k++)
            queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        wait_until_drained();
        repeat (5) @(posedge clk);

        $display("Checked %0d results from %0d ticks across %0d register writes.",
                 results_checked, ticks_queued, cfg_writes);
        $display("Results per mode: idle %0d, alert %0d, muted %0d, siren %0d.",
                 mode_seen[MODE_IDLE], mode_seen[MODE_ALERT], mode_seen[MODE_MUTED],
                 mode_seen[MODE_SIREN]);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
